// ===== src/single_source_shortest_paths_top_defines.svh =====
// Assertion macros used by the shortest path search datapath.
`ifndef SINGLE_SOURCE_SHORTEST_PATHS_TOP_DEFINES_SVH
`define SINGLE_SOURCE_SHORTEST_PATHS_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSSP_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SSSP_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/sssp_pkg.sv =====
// Shared types, constants and microcode table of the shortest path search block.
`timescale 1ns / 1ps

package sssp_pkg;

	// Fixed field widths.
	localparam int DIST_W = 21;
	localparam int NODE_W = 5;
	localparam int WIN_W  = 16;
	localparam int NCNT_W = 6;

	// Defaults for the top level parameters.
	localparam int MAX_VERTICES_DEF = 32;
	localparam int WEIGHT_BITS_DEF  = 16;

	// Configuration port.
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic [NCNT_W-1:0] NCNT_RESET = 6'd32;
	localparam logic [APB_AW-3:0] REG_NODE_COUNT = 1'b0;

	// Datapath operations selected by the control word.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_IDLE,
		OP_INIT,
		OP_ROUND,
		OP_SETTLE,
		OP_PASS,
		OP_DRAIN,
		OP_EMIT
	} op_t;

	// Jump conditions.
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_CLR_BUSY,
		C_NO_QUERY,
		C_SEARCH_DONE,
		C_PASS_MORE,
		C_EMIT_MORE
	} cond_t;

	typedef logic [3:0] step_t;

	// Program step addresses.
	localparam step_t ST_CLEAR  = 4'd0;
	localparam step_t ST_IDLE   = 4'd1;
	localparam step_t ST_INIT   = 4'd2;
	localparam step_t ST_ROUND  = 4'd3;
	localparam step_t ST_SETTLE = 4'd4;
	localparam step_t ST_PASS   = 4'd5;
	localparam step_t ST_DRAIN  = 4'd6;
	localparam step_t ST_EMIT   = 4'd7;
	localparam step_t ST_DONE   = 4'd8;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ctrl_t;

	// Status flags from the datapath that the jump conditions test.
	typedef struct packed {
		logic clr_last;
		logic query_go;
		logic search_done;
		logic pass_last;
		logic emit_last;
	} stat_t;

	// Microcode table: one control word per program step.
	function automatic ctrl_t ucode(step_t s);
		ctrl_t cw;
		unique case (s)
			ST_CLEAR:  cw = '{op: OP_CLEAR,  cond: C_CLR_BUSY,    target: ST_CLEAR};
			ST_IDLE:   cw = '{op: OP_IDLE,   cond: C_NO_QUERY,    target: ST_IDLE};
			ST_INIT:   cw = '{op: OP_INIT,   cond: C_NEVER,       target: ST_IDLE};
			ST_ROUND:  cw = '{op: OP_ROUND,  cond: C_SEARCH_DONE, target: ST_EMIT};
			ST_SETTLE: cw = '{op: OP_SETTLE, cond: C_NEVER,       target: ST_IDLE};
			ST_PASS:   cw = '{op: OP_PASS,   cond: C_PASS_MORE,   target: ST_PASS};
			ST_DRAIN:  cw = '{op: OP_DRAIN,  cond: C_ALWAYS,      target: ST_ROUND};
			ST_EMIT:   cw = '{op: OP_EMIT,   cond: C_EMIT_MORE,   target: ST_EMIT};
			ST_DONE:   cw = '{op: OP_NONE,   cond: C_ALWAYS,      target: ST_IDLE};
			default:   cw = '{op: OP_NONE,   cond: C_ALWAYS,      target: ST_IDLE};
		endcase
		return cw;
	endfunction

endpackage

// ===== src/sssp_seq.sv =====
// Microcode sequencer: step counter, control word table lookup and conditional jumps.
`timescale 1ns / 1ps

module sssp_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  sssp_pkg::stat_t stat,
	output sssp_pkg::ctrl_t cw
);

	sssp_pkg::step_t upc_q;
	logic            take;

	// Fetch the control word of the current step.
	assign cw = sssp_pkg::ucode(upc_q);

	// Evaluate the jump condition.
	always_comb begin
		unique case (cw.cond)
			sssp_pkg::C_NEVER:       take = 1'b0;
			sssp_pkg::C_ALWAYS:      take = 1'b1;
			sssp_pkg::C_CLR_BUSY:    take = !stat.clr_last;
			sssp_pkg::C_NO_QUERY:    take = !stat.query_go;
			sssp_pkg::C_SEARCH_DONE: take = stat.search_done;
			sssp_pkg::C_PASS_MORE:   take = !stat.pass_last;
			sssp_pkg::C_EMIT_MORE:   take = !stat.emit_last;
			default:                 take = 1'b1;
		endcase
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= sssp_pkg::ST_CLEAR;
		end else if (take) begin
			upc_q <= cw.target;
		end else begin
			upc_q <= upc_q + 1'b1;
		end
	end

endmodule

// ===== src/sssp_dp.sv =====
// Search datapath: weight memory, distance store, relax and minimum search, result register.
`timescale 1ns / 1ps
`include "single_source_shortest_paths_top_defines.svh"

module sssp_dp #(
	parameter int MAX_VERTICES = sssp_pkg::MAX_VERTICES_DEF,
	parameter int WEIGHT_BITS  = sssp_pkg::WEIGHT_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sssp_pkg::ctrl_t             cw,
	output sssp_pkg::stat_t             stat,
	input  logic [sssp_pkg::NCNT_W-1:0] node_count,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        mode,
	input  logic [sssp_pkg::NODE_W-1:0] row_node,
	input  logic [sssp_pkg::NODE_W-1:0] col_node,
	input  logic [sssp_pkg::WIN_W-1:0]  edge_weight,
	input  logic [sssp_pkg::NODE_W-1:0] source_node,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [sssp_pkg::NODE_W-1:0] node_index,
	output logic [sssp_pkg::DIST_W-1:0] path_length,
	output logic                        reachable,
	output logic                        last_result
);

	localparam int VW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int AW    = 2 * VW;
	localparam int DEPTH = 2 ** AW;
	localparam int DW    = sssp_pkg::DIST_W;
	localparam int SW    = DW + 1;
	localparam int NW    = sssp_pkg::NODE_W;
	localparam int WIW   = sssp_pkg::WIN_W;
	localparam int WSW   = (WEIGHT_BITS < WIW) ? WEIGHT_BITS : WIW;
	localparam logic [DW-1:0] DIST_SAT = '1;

	// Weight memory and its read register.
	logic [WSW-1:0] wmem [0:DEPTH-1];
	logic [WSW-1:0] rdata_q;
	logic [AW-1:0]  clr_q;

	// Per-node search state.
	logic [DW-1:0]           dist_q [0:MAX_VERTICES-1];
	logic [MAX_VERTICES-1:0] settled_q;
	logic [MAX_VERTICES-1:0] dvalid_q;

	// Sequencing registers.
	logic [VW-1:0] vidx_q;
	logic [VW-1:0] pick_q;
	logic [VW-1:0] src_q;
	logic [VW-1:0] rounds_q;
	logic [VW-1:0] rv_s1;
	logic [VW-1:0] cand_idx_q;
	logic [DW-1:0] pdist_q;
	logic [DW-1:0] cand_dist_q;
	logic          found_q;
	logic          src_ok_q;
	logic          pvld_s1;
	logic          cand_found_q;

	// Result register.
	logic          out_valid_q;
	logic [NW-1:0] node_index_q;
	logic [DW-1:0] path_length_q;
	logic          reachable_q;
	logic          last_q;

	logic [VW-1:0] n_last;
	logic          in_acc;
	logic          load_acc;
	logic          query_acc;
	logic          cell_ok;
	logic [VW-1:0] wr_row;
	logic [VW-1:0] wr_col;
	logic [VW-1:0] rd_idx;
	logic [DW-1:0] d_cur;
	logic          dv_cur;
	logic          st_cur;
	logic          proc_en;
	logic [SW-1:0] sum;
	logic [DW-1:0] sat;
	logic          upd;
	logic          new_valid;
	logic [DW-1:0] new_dist;
	logic          take_cand;
	logic          out_free;
	logic          emit_ld;

	// Index of the last node in use, with the node count clamped to 1..MAX_VERTICES.
	always_comb begin
		if (node_count == '0) begin
			n_last = '0;
		end else if (int'(node_count) > MAX_VERTICES) begin
			n_last = VW'(MAX_VERTICES - 1);
		end else begin
			n_last = VW'(node_count - 1'b1);
		end
	end

	// Input word handshake; words are taken only in the idle step.
	assign in_stall  = (cw.op != sssp_pkg::OP_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign load_acc  = in_acc && !mode;
	assign query_acc = in_acc && mode;
	assign cell_ok   = (int'(row_node) < MAX_VERTICES) && (int'(col_node) < MAX_VERTICES);
	assign wr_row    = VW'(row_node);
	assign wr_col    = VW'(col_node);

	// Weight memory: clearing sweep or load write, and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (cw.op == sssp_pkg::OP_CLEAR) begin
			wmem[clr_q] <= '0;
		end else if (load_acc && cell_ok) begin
			wmem[{wr_row, wr_col}] <= edge_weight[WSW-1:0];
		end
		rdata_q <= wmem[{pick_q, vidx_q}];
	end

	// One shared read port into the per-node state.
	always_comb begin
		unique case (cw.op)
			sssp_pkg::OP_SETTLE: rd_idx = pick_q;
			sssp_pkg::OP_EMIT:   rd_idx = vidx_q;
			default:             rd_idx = rv_s1;
		endcase
		d_cur  = dist_q[rd_idx];
		dv_cur = dvalid_q[rd_idx];
		st_cur = settled_q[rd_idx];
	end

	// Relax one edge of the settled node and track the next minimum in the same pass.
	always_comb begin
		proc_en   = ((cw.op == sssp_pkg::OP_PASS) && pvld_s1) || (cw.op == sssp_pkg::OP_DRAIN);
		sum       = {1'b0, pdist_q} + SW'(rdata_q);
		sat       = sum[DW] ? DIST_SAT : sum[DW-1:0];
		upd       = proc_en && !st_cur && (rdata_q != '0) && (!dv_cur || (sat < d_cur));
		new_valid = dv_cur || upd;
		new_dist  = upd ? sat : d_cur;
		take_cand = proc_en && !st_cur && new_valid &&
			(!cand_found_q || (new_dist < cand_dist_q));
	end

	// Result register is free when empty or being taken.
	assign out_free = !out_valid_q || !out_stall;
	assign emit_ld  = (cw.op == sssp_pkg::OP_EMIT) && out_free;

	// Status back to the sequencer.
	always_comb begin
		stat.clr_last    = &clr_q;
		stat.query_go    = query_acc;
		stat.search_done = !found_q || (rounds_q == n_last);
		stat.pass_last   = (vidx_q == n_last);
		stat.emit_last   = out_free && (vidx_q == n_last);
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= '0;
			vidx_q       <= '0;
			rounds_q     <= '0;
			found_q      <= 1'b0;
			pvld_s1      <= 1'b0;
			cand_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cw.op == sssp_pkg::OP_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cw.op == sssp_pkg::OP_ROUND) begin
				vidx_q <= '0;
			end else if ((cw.op == sssp_pkg::OP_PASS) || emit_ld) begin
				vidx_q <= vidx_q + 1'b1;
			end
			if (cw.op == sssp_pkg::OP_INIT) begin
				rounds_q <= '0;
				found_q  <= src_ok_q;
			end else if (cw.op == sssp_pkg::OP_SETTLE) begin
				rounds_q <= rounds_q + 1'b1;
			end else if (cw.op == sssp_pkg::OP_DRAIN) begin
				found_q <= cand_found_q || take_cand;
			end
			pvld_s1 <= (cw.op == sssp_pkg::OP_PASS);
			if (cw.op == sssp_pkg::OP_SETTLE) begin
				cand_found_q <= 1'b0;
			end else if (take_cand) begin
				cand_found_q <= 1'b1;
			end
			if (emit_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Search state and result payload.
	always_ff @(posedge clk) begin
		if (query_acc) begin
			src_q    <= VW'(source_node);
			src_ok_q <= int'(source_node) <= int'(n_last);
		end
		if (cw.op == sssp_pkg::OP_INIT) begin
			// Only the source starts with a known distance.
			settled_q <= '0;
			dvalid_q  <= src_ok_q ? (MAX_VERTICES'(1) << src_q) : '0;
			pick_q    <= src_q;
			if (src_ok_q) begin
				dist_q[src_q] <= '0;
			end
		end
		if (cw.op == sssp_pkg::OP_SETTLE) begin
			settled_q[pick_q] <= 1'b1;
			pdist_q           <= d_cur;
		end
		if (cw.op == sssp_pkg::OP_PASS) begin
			rv_s1 <= vidx_q;
		end
		if (upd) begin
			dist_q[rv_s1]   <= sat;
			dvalid_q[rv_s1] <= 1'b1;
		end
		if (take_cand) begin
			cand_idx_q  <= rv_s1;
			cand_dist_q <= new_dist;
		end
		if (cw.op == sssp_pkg::OP_DRAIN) begin
			pick_q <= take_cand ? rv_s1 : cand_idx_q;
		end
		if (emit_ld) begin
			node_index_q  <= NW'(vidx_q);
			path_length_q <= dv_cur ? d_cur : '0;
			reachable_q   <= dv_cur;
			last_q        <= (vidx_q == n_last);
		end
	end

	// Result word outputs.
	assign out_valid   = out_valid_q;
	assign node_index  = node_index_q;
	assign path_length = path_length_q;
	assign reachable   = reachable_q;
	assign last_result = last_q;

	// Checks on the search sequencing.
	`SSSP_ASSERT_IMP(a_settle_pick, clk, arst_n, cw.op == sssp_pkg::OP_SETTLE, !settled_q[pick_q] && dvalid_q[pick_q], "settled node picked again or picked without a distance")
	`SSSP_ASSERT_IMP(a_settle_count, clk, arst_n, cw.op == sssp_pkg::OP_PASS, $countones(settled_q) == int'(rounds_q), "settled count differs from round count")
	`SSSP_ASSERT_NXT(a_pass_row, clk, arst_n, cw.op == sssp_pkg::OP_PASS, $stable(pick_q), "weight row changed during a relax pass")
	`SSSP_ASSERT_IMP(a_drain_data, clk, arst_n, cw.op == sssp_pkg::OP_DRAIN, pvld_s1, "drain step without a pending read")

endmodule

// ===== src/single_source_shortest_paths_top.sv =====
// Top level of the dense-matrix shortest path search block with its register port.
//
//   channel   direction  handshake            payload
//   input     in         in_valid / in_stall  mode, row_node, col_node, edge_weight, source_node
//   result    out        out_valid/out_stall  node_index, path_length, reachable, last_result
//   config    in         APB psel/penable     node_count at byte address 0
//
// After reset a clearing pass zeroes all 2**(2*ceil(log2(MAX_VERTICES))) weight memory
// entries (1024 by default); no word is taken during it.
// Load words are taken back to back in the idle step. A query runs one microcode pass
// over a weight row per settled node.
// Results leave through one output register; out_stall holds the sequencer in its emit step.
`timescale 1ns / 1ps

module single_source_shortest_paths_top #(
	parameter int MAX_VERTICES = sssp_pkg::MAX_VERTICES_DEF,
	parameter int WEIGHT_BITS  = sssp_pkg::WEIGHT_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        mode,
	input  logic [sssp_pkg::NODE_W-1:0] row_node,
	input  logic [sssp_pkg::NODE_W-1:0] col_node,
	input  logic [sssp_pkg::WIN_W-1:0]  edge_weight,
	input  logic [sssp_pkg::NODE_W-1:0] source_node,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [sssp_pkg::NODE_W-1:0] node_index,
	output logic [sssp_pkg::DIST_W-1:0] path_length,
	output logic                        reachable,
	output logic                        last_result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sssp_pkg::APB_AW-1:0] paddr,
	input  logic [sssp_pkg::APB_DW-1:0] pwdata,
	output logic [sssp_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);

	logic [sssp_pkg::NCNT_W-1:0] node_count_q;
	logic [sssp_pkg::APB_AW-3:0] reg_idx;
	logic                        reg_hit;
	sssp_pkg::ctrl_t             cw;
	sssp_pkg::stat_t             stat;

	// Register decode.
	assign reg_idx = paddr[sssp_pkg::APB_AW-1:2];
	assign reg_hit = (reg_idx == sssp_pkg::REG_NODE_COUNT);
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? sssp_pkg::APB_DW'(node_count_q) : '0;

	// Node count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= sssp_pkg::NCNT_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			node_count_q <= pwdata[sssp_pkg::NCNT_W-1:0];
		end
	end

	// Microcode sequencer.
	sssp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cw     (cw)
	);

	// Datapath.
	sssp_dp #(
		.MAX_VERTICES (MAX_VERTICES),
		.WEIGHT_BITS  (WEIGHT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cw          (cw),
		.stat        (stat),
		.node_count  (node_count_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.row_node    (row_node),
		.col_node    (col_node),
		.edge_weight (edge_weight),
		.source_node (source_node),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.node_index  (node_index),
		.path_length (path_length),
		.reachable   (reachable),
		.last_result (last_result)
	);

endmodule
